FILE: hw/rtl/triangle_face_normal_macros.svh
// assertion macros shared by the triangle face normal rtl
`ifndef TRIANGLE_FACE_NORMAL_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_MACROS_SVH

// same-cycle implication, checked outside reset
`define TFN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("triangle_face_normal check failed");

// next-cycle implication, checked outside reset
`define TFN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("triangle_face_normal check failed");

`endif

FILE: hw/rtl/tfn_pkg.sv
// shared constants and control types for the triangle face normal pipeline
`timescale 1ns / 1ps
package tfn_pkg;
    localparam int COORD_BITS_DEF       = 24;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    typedef struct packed {
        logic       valid;
        logic       degen;
        logic [2:0] neg;
    } t_ctl;
endpackage

FILE: hw/rtl/triangle_face_normal.sv
// triangle face normal top level: cross product, squares, scaling steps, output
//
//  channel   valid     stall     payload
//  input     i_valid   o_stall   i_p0_x .. i_p2_z
//  output    o_valid   i_stall   o_normal_x/y/z, o_degenerate
//
// one triangle is taken every cycle unless o_stall is high; the path is 4 cross
// stages, 3 square stages, one scaling step per result bit and the output
// register
// reset is synchronous and clears only the valid bits
// a beat held at the output freezes every stage, so o_stall follows i_stall
`timescale 1ns / 1ps
`include "triangle_face_normal_macros.svh"
module triangle_face_normal #(
    parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [COORD_BITS-1:0]       i_p0_x,
    input  logic signed [COORD_BITS-1:0]       i_p0_y,
    input  logic signed [COORD_BITS-1:0]       i_p0_z,
    input  logic signed [COORD_BITS-1:0]       i_p1_x,
    input  logic signed [COORD_BITS-1:0]       i_p1_y,
    input  logic signed [COORD_BITS-1:0]       i_p1_z,
    input  logic signed [COORD_BITS-1:0]       i_p2_x,
    input  logic signed [COORD_BITS-1:0]       i_p2_y,
    input  logic signed [COORD_BITS-1:0]       i_p2_z,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [NORMAL_FRAC_BITS+1:0] o_normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0] o_normal_y,
    output logic signed [NORMAL_FRAC_BITS+1:0] o_normal_z,
    output logic                               o_degenerate
);
    localparam int MW = 2 * COORD_BITS + 1;
    localparam int SW = 4 * COORD_BITS + 4;
    localparam int AW = SW + 2 * NORMAL_FRAC_BITS + 4;
    localparam int QW = NORMAL_FRAC_BITS + 1;
    localparam int OW = NORMAL_FRAC_BITS + 2;
    localparam int NS = NORMAL_FRAC_BITS + 2;
    localparam logic signed [OW-1:0] NMAX = OW'(1) << NORMAL_FRAC_BITS;

    logic          w_en;
    tfn_pkg::t_ctl w_ctl_x, w_ctl_s;
    logic [MW-1:0] w_mag [3];
    tfn_pkg::t_ctl w_ctl [NS];
    logic [SW-1:0] w_s [NS];
    logic [AW-1:0] w_r [NS][3];
    logic [AW-1:0] w_t [NS][3];
    logic [QW-1:0] w_q [NS][3];
    logic [OW-1:0] n_n [3];

    logic                 r_o_valid;
    logic                 r_o_degen;
    logic signed [OW-1:0] r_o_n [3];

    assign w_en    = !(r_o_valid && i_stall);
    assign o_stall = r_o_valid && i_stall;

    tfn_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_p0_x  (i_p0_x),
        .i_p0_y  (i_p0_y),
        .i_p0_z  (i_p0_z),
        .i_p1_x  (i_p1_x),
        .i_p1_y  (i_p1_y),
        .i_p1_z  (i_p1_z),
        .i_p2_x  (i_p2_x),
        .i_p2_y  (i_p2_y),
        .i_p2_z  (i_p2_z),
        .o_ctl   (w_ctl_x),
        .o_mag   (w_mag)
    );

    tfn_square #(
        .COORD_BITS       (COORD_BITS),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_ctl_x),
        .i_mag   (w_mag),
        .o_ctl   (w_ctl_s),
        .o_s     (w_s[0]),
        .o_r     (w_r[0])
    );

    assign w_ctl[0] = w_ctl_s;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_t[0][i] = '0;
            w_q[0][i] = '0;
        end
    end

    for (genvar k = 0; k < NS - 1; k++) begin : g_step
        tfn_unit_step #(
            .COORD_BITS       (COORD_BITS),
            .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
            .BIT              (NORMAL_FRAC_BITS - k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[k]),
            .i_s     (w_s[k]),
            .i_r     (w_r[k]),
            .i_t     (w_t[k]),
            .i_q     (w_q[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_s     (w_s[k+1]),
            .o_r     (w_r[k+1]),
            .o_t     (w_t[k+1]),
            .o_q     (w_q[k+1])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_ctl[NS-1].degen) begin
                n_n[i] = '0;
            end else if (w_ctl[NS-1].neg[i]) begin
                n_n[i] = -OW'(w_q[NS-1][i]);
            end else begin
                n_n[i] = OW'(w_q[NS-1][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_ctl[NS-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_degen <= w_ctl[NS-1].degen;
            for (int i = 0; i < 3; i++) begin
                r_o_n[i] <= n_n[i];
            end
        end
    end

    assign o_valid      = r_o_valid;
    assign o_degenerate = r_o_degen;
    assign o_normal_x   = r_o_n[0];
    assign o_normal_y   = r_o_n[1];
    assign o_normal_z   = r_o_n[2];

    `TFN_ASSERT_NOW(a_degen_zero, i_clk, i_rst_n, o_valid && o_degenerate, o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0)
    `TFN_ASSERT_NOW(a_nonzero, i_clk, i_rst_n, o_valid && !o_degenerate, o_normal_x != '0 || o_normal_y != '0 || o_normal_z != '0)
    `TFN_ASSERT_NOW(a_range, i_clk, i_rst_n, o_valid, o_normal_x <= NMAX && o_normal_x >= -NMAX && o_normal_y <= NMAX && o_normal_y >= -NMAX && o_normal_z <= NMAX && o_normal_z >= -NMAX)
    `TFN_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, o_stall, o_valid)
endmodule

FILE: hw/rtl/tfn_cross.sv
// edge vectors, exact cross product, component magnitudes and signs
`timescale 1ns / 1ps
module tfn_cross #(
    parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_p0_x,
    input  logic signed [COORD_BITS-1:0] i_p0_y,
    input  logic signed [COORD_BITS-1:0] i_p0_z,
    input  logic signed [COORD_BITS-1:0] i_p1_x,
    input  logic signed [COORD_BITS-1:0] i_p1_y,
    input  logic signed [COORD_BITS-1:0] i_p1_z,
    input  logic signed [COORD_BITS-1:0] i_p2_x,
    input  logic signed [COORD_BITS-1:0] i_p2_y,
    input  logic signed [COORD_BITS-1:0] i_p2_z,
    output tfn_pkg::t_ctl                o_ctl,
    output logic [2*COORD_BITS:0]        o_mag [3]
);
    localparam int EW = COORD_BITS + 1;
    localparam int PW = 2 * EW;
    localparam int CW = PW + 1;
    localparam int MW = 2 * COORD_BITS + 1;

    logic signed [EW-1:0] r_a [3];
    logic signed [EW-1:0] r_b [3];
    logic signed [PW-1:0] r_pp [3];
    logic signed [PW-1:0] r_pq [3];
    logic signed [CW-1:0] r_c [3];
    logic [MW-1:0]        r_mag [3];
    logic [2:0]           r_neg;
    logic                 r_degen;
    logic                 r_v1, r_v2, r_v3, r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // edges p1 - p0 and p2 - p0
            r_a[0] <= EW'(i_p1_x) - EW'(i_p0_x);
            r_a[1] <= EW'(i_p1_y) - EW'(i_p0_y);
            r_a[2] <= EW'(i_p1_z) - EW'(i_p0_z);
            r_b[0] <= EW'(i_p2_x) - EW'(i_p0_x);
            r_b[1] <= EW'(i_p2_y) - EW'(i_p0_y);
            r_b[2] <= EW'(i_p2_z) - EW'(i_p0_z);
            r_pp[0] <= r_a[1] * r_b[2];
            r_pq[0] <= r_a[2] * r_b[1];
            r_pp[1] <= r_a[2] * r_b[0];
            r_pq[1] <= r_a[0] * r_b[2];
            r_pp[2] <= r_a[0] * r_b[1];
            r_pq[2] <= r_a[1] * r_b[0];
            for (int i = 0; i < 3; i++) begin
                r_c[i]   <= CW'(r_pp[i]) - CW'(r_pq[i]);
                r_mag[i] <= r_c[i][CW-1] ? MW'(-r_c[i]) : MW'(r_c[i]);
                r_neg[i] <= r_c[i][CW-1];
            end
            r_degen <= (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
        end
    end

    assign o_ctl.valid = r_v4;
    assign o_ctl.degen = r_degen;
    assign o_ctl.neg   = r_neg;
    assign o_mag       = r_mag;
endmodule

FILE: hw/rtl/tfn_square.sv
// squared length of the cross product and scaled component squares
`timescale 1ns / 1ps
module tfn_square #(
    parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_en,
    input  tfn_pkg::t_ctl                             i_ctl,
    input  logic [2*COORD_BITS:0]                     i_mag [3],
    output tfn_pkg::t_ctl                             o_ctl,
    output logic [4*COORD_BITS+3:0]                   o_s,
    output logic [4*COORD_BITS+2*NORMAL_FRAC_BITS+7:0] o_r [3]
);
    localparam int MW  = 2 * COORD_BITS + 1;
    localparam int LW  = (MW + 1) / 2;
    localparam int HW  = MW - LW;
    localparam int SQW = 2 * MW;
    localparam int SW  = SQW + 2;
    localparam int AW  = SW + 2 * NORMAL_FRAC_BITS + 4;

    logic [2*HW-1:0]    r_hh [3];
    logic [HW+LW-1:0]   r_hl [3];
    logic [2*LW-1:0]    r_ll [3];
    logic [SQW-1:0]     r_sq [3];
    logic [SW-1:0]      r_s;
    logic [AW-1:0]      r_r [3];
    tfn_pkg::t_ctl      r_ctl1, r_ctl2, r_ctl3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1.valid <= 1'b0;
            r_ctl2.valid <= 1'b0;
            r_ctl3.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl1.valid <= i_ctl.valid;
            r_ctl2.valid <= r_ctl1.valid;
            r_ctl3.valid <= r_ctl2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl1.degen <= i_ctl.degen;
            r_ctl1.neg   <= i_ctl.neg;
            r_ctl2.degen <= r_ctl1.degen;
            r_ctl2.neg   <= r_ctl1.neg;
            r_ctl3.degen <= r_ctl2.degen;
            r_ctl3.neg   <= r_ctl2.neg;
            // split squares into half-width partial products
            for (int i = 0; i < 3; i++) begin
                r_hh[i] <= i_mag[i][MW-1:LW] * i_mag[i][MW-1:LW];
                r_hl[i] <= i_mag[i][MW-1:LW] * i_mag[i][LW-1:0];
                r_ll[i] <= i_mag[i][LW-1:0] * i_mag[i][LW-1:0];
                r_sq[i] <= (SQW'(r_hh[i]) << (2 * LW)) + (SQW'(r_hl[i]) << (LW + 1))
                         + SQW'(r_ll[i]);
                r_r[i]  <= AW'(r_sq[i]) << (2 * NORMAL_FRAC_BITS);
            end
            r_s <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
        end
    end

    assign o_ctl = r_ctl3;
    assign o_s   = r_s;
    assign o_r   = r_r;
endmodule

FILE: hw/rtl/tfn_unit_step.sv
// one result bit of the unit-length scaling for all three components
`timescale 1ns / 1ps
module tfn_unit_step #(
    parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF,
    parameter int BIT              = 0
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_en,
    input  tfn_pkg::t_ctl                             i_ctl,
    input  logic [4*COORD_BITS+3:0]                   i_s,
    input  logic [4*COORD_BITS+2*NORMAL_FRAC_BITS+7:0] i_r [3],
    input  logic [4*COORD_BITS+2*NORMAL_FRAC_BITS+7:0] i_t [3],
    input  logic [NORMAL_FRAC_BITS:0]                 i_q [3],
    output tfn_pkg::t_ctl                             o_ctl,
    output logic [4*COORD_BITS+3:0]                   o_s,
    output logic [4*COORD_BITS+2*NORMAL_FRAC_BITS+7:0] o_r [3],
    output logic [4*COORD_BITS+2*NORMAL_FRAC_BITS+7:0] o_t [3],
    output logic [NORMAL_FRAC_BITS:0]                 o_q [3]
);
    localparam int SW = 4 * COORD_BITS + 4;
    localparam int AW = SW + 2 * NORMAL_FRAC_BITS + 4;
    localparam int QW = NORMAL_FRAC_BITS + 1;

    logic [AW-1:0] w_sb;
    logic [AW-1:0] w_d [3];
    logic [2:0]    w_take;
    logic [AW-1:0] n_r [3];
    logic [AW-1:0] n_t [3];
    logic [QW-1:0] n_q [3];

    logic [AW-1:0] r_r [3];
    logic [AW-1:0] r_t [3];
    logic [QW-1:0] r_q [3];
    logic [SW-1:0] r_s;
    tfn_pkg::t_ctl r_ctl;

    // remainder r = m^2 2^2F - q^2 s, running t = q s
    always_comb begin
        w_sb = {{(AW-SW){1'b0}}, i_s} << BIT;
        for (int i = 0; i < 3; i++) begin
            w_d[i]    = ((i_t[i] << 1) + w_sb) << BIT;
            w_take[i] = w_d[i] <= i_r[i];
            n_r[i]    = w_take[i] ? i_r[i] - w_d[i] : i_r[i];
            n_t[i]    = w_take[i] ? i_t[i] + w_sb : i_t[i];
            n_q[i]    = i_q[i] | (QW'(w_take[i]) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl.degen <= i_ctl.degen;
            r_ctl.neg   <= i_ctl.neg;
            r_s         <= i_s;
            r_r         <= n_r;
            r_t         <= n_t;
            r_q         <= n_q;
        end
    end

    assign o_ctl = r_ctl;
    assign o_s   = r_s;
    assign o_r   = r_r;
    assign o_t   = r_t;
    assign o_q   = r_q;
endmodule

FILE: tb/tb_triangle_face_normal.sv
// testbench for triangle_face_normal: directed table then random triangles, checked beat by beat
`timescale 1ns / 1ps
module tb_triangle_face_normal;
    localparam int N_RANDOM = 930;
    localparam int LIMIT = 200000;
    localparam logic signed [23:0] CMAX = 24'sh7fffff;
    localparam logic signed [23:0] CMIN = 24'sh800000;

    typedef struct packed {
        logic signed [23:0] p0x, p0y, p0z, p1x, p1y, p1z, p2x, p2y, p2z;
    } tri_t;

    typedef struct packed {
        logic signed [15:0] nx, ny, nz;
        logic               degen;
    } norm_t;

    typedef struct packed {
        tri_t  t;
        logic  typed;
        norm_t e;
    } row_t;

    logic i_clk, i_rst_n, i_valid, i_stall, o_stall, o_valid, o_degenerate;
    logic signed [23:0] i_p0_x, i_p0_y, i_p0_z, i_p1_x, i_p1_y, i_p1_z;
    logic signed [23:0] i_p2_x, i_p2_y, i_p2_z;
    logic signed [15:0] o_normal_x, o_normal_y, o_normal_z;

    norm_t normal_q[$];
    int    errors = 0;
    int    cycles = 0;
    int    beats = 0;
    row_t  dir_tab [12];

    triangle_face_normal dut (.*);

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic signed [15:0] unit_comp(longint c, logic [191:0] s);
        logic [191:0] m, rhs;
        longint q, cand;
        q = 0;
        m = (c < 0) ? 192'(-c) : 192'(c);
        rhs = (m * m) << 28;
        for (int b = 14; b >= 0; b--) begin
            cand = q | (64'd1 << b);
            if (192'(cand * cand) * s <= rhs) q = cand;
        end
        return (c < 0) ? 16'(-q) : 16'(q);
    endfunction

    function automatic norm_t face_normal(tri_t t);
        longint ax, ay, az, bx, by, bz, cx, cy, cz;
        logic [191:0] s;
        norm_t n;
        ax = longint'(t.p1x) - longint'(t.p0x);
        ay = longint'(t.p1y) - longint'(t.p0y);
        az = longint'(t.p1z) - longint'(t.p0z);
        bx = longint'(t.p2x) - longint'(t.p0x);
        by = longint'(t.p2y) - longint'(t.p0y);
        bz = longint'(t.p2z) - longint'(t.p0z);
        cx = ay * bz - az * by;
        cy = az * bx - ax * bz;
        cz = ax * by - ay * bx;
        s = 192'(cx < 0 ? -cx : cx) * 192'(cx < 0 ? -cx : cx)
          + 192'(cy < 0 ? -cy : cy) * 192'(cy < 0 ? -cy : cy)
          + 192'(cz < 0 ? -cz : cz) * 192'(cz < 0 ? -cz : cz);
        if (s == 0) begin
            n = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
        end else begin
            n = '{unit_comp(cx, s), unit_comp(cy, s), unit_comp(cz, s), 1'b0};
        end
        return n;
    endfunction

    function automatic tri_t random_tri();
        tri_t t;
        logic signed [23:0] d [3];
        int k, sh;
        t = tri_t'(216'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom}));
        case ($urandom_range(0, 9))
            6, 7: begin
                // small triangle around a random origin
                sh = $urandom_range(0, 20);
                t.p0x = 24'($signed($urandom_range(0, 8388607)) - 4194304);
                t.p0y = 24'($signed($urandom_range(0, 8388607)) - 4194304);
                t.p0z = 24'($signed($urandom_range(0, 8388607)) - 4194304);
                t.p1x = t.p0x + 24'($signed($urandom) >>> (31 - sh));
                t.p1y = t.p0y + 24'($signed($urandom) >>> (31 - sh));
                t.p1z = t.p0z + 24'($signed($urandom) >>> (31 - sh));
                t.p2x = t.p0x + 24'($signed($urandom) >>> (31 - sh));
                t.p2y = t.p0y + 24'($signed($urandom) >>> (31 - sh));
                t.p2z = t.p0z + 24'($signed($urandom) >>> (31 - sh));
            end
            8: begin
                // collinear, degenerate
                k = $urandom_range(0, 6) - 3;
                for (int i = 0; i < 3; i++) d[i] = 24'($urandom_range(0, 2000)) - 24'sd1000;
                t.p0x = 24'($urandom_range(0, 200000)) - 24'sd100000;
                t.p0y = 24'($urandom_range(0, 200000)) - 24'sd100000;
                t.p0z = 24'($urandom_range(0, 200000)) - 24'sd100000;
                t.p1x = t.p0x + d[0];
                t.p1y = t.p0y + d[1];
                t.p1z = t.p0z + d[2];
                t.p2x = t.p0x + 24'(d[0] * k);
                t.p2y = t.p0y + 24'(d[1] * k);
                t.p2z = t.p0z + 24'(d[2] * k);
            end
            9: begin
                // flat in one plane: normal along an axis
                t.p1z = t.p0z;
                t.p2z = t.p0z;
            end
            default: ;
        endcase
        return t;
    endfunction

    task automatic check_beat();
        norm_t e;
        if (normal_q.size() == 0) begin
            $display("%0t: unexpected beat x=%0d y=%0d z=%0d degenerate=%0b", $time,
                     o_normal_x, o_normal_y, o_normal_z, o_degenerate);
            errors++;
        end else begin
            e = normal_q.pop_front();
            if (o_normal_x !== e.nx) begin
                $display("%0t: normal_x expected %0d got %0d", $time, e.nx, o_normal_x);
                errors++;
            end
            if (o_normal_y !== e.ny) begin
                $display("%0t: normal_y expected %0d got %0d", $time, e.ny, o_normal_y);
                errors++;
            end
            if (o_normal_z !== e.nz) begin
                $display("%0t: normal_z expected %0d got %0d", $time, e.nz, o_normal_z);
                errors++;
            end
            if (o_degenerate !== e.degen) begin
                $display("%0t: degenerate expected %0b got %0b", $time, e.degen, o_degenerate);
                errors++;
            end
        end
    endtask

    // receiver: random holds per beat, quiet stretches, one long hold
    initial begin
        int hold_cnt;
        bit long_done;
        hold_cnt = 0;
        long_done = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                check_beat();
                beats++;
                hold_cnt = ((beats / 80) % 3 == 0) ? 0 : $urandom_range(0, 5);
            end
            if (beats == 300 && !long_done) begin
                long_done = 1;
                i_stall <= 1'b1;
                repeat (200) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (hold_cnt > 0) begin
                i_stall <= 1'b1;
                hold_cnt--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_tri(tri_t t, int idx, logic typed, norm_t e, bit drain);
        int gap;
        gap = ((idx / 100) % 3 == 1) ? 0 : $urandom_range(0, 5);
        if (gap > 0 || drain) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            if (drain) begin
                do @(posedge i_clk); while (normal_q.size() != 0);
            end
        end
        {i_p0_x, i_p0_y, i_p0_z, i_p1_x, i_p1_y, i_p1_z, i_p2_x, i_p2_y, i_p2_z} <= t;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        normal_q.push_back(typed ? e : face_normal(t));
    endtask

    initial begin
        norm_t none;
        none = '0;
        dir_tab[0]  = '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b1}};
        dir_tab[1]  = '{'{0, 0, 0, 1, 0, 0, 0, 1, 0}, 1'b1, '{16'sd0, 16'sd0, 16'sd16384, 1'b0}};
        dir_tab[2]  = '{'{0, 0, 0, 0, 1, 0, 1, 0, 0}, 1'b1, '{16'sd0, 16'sd0, -16'sd16384, 1'b0}};
        dir_tab[3]  = '{'{0, 0, 0, 0, 1, 0, 0, 0, 1}, 1'b1, '{16'sd16384, 16'sd0, 16'sd0, 1'b0}};
        dir_tab[4]  = '{'{0, 0, 0, 0, 0, 1, 1, 0, 0}, 1'b1, '{16'sd0, 16'sd16384, 16'sd0, 1'b0}};
        dir_tab[5]  = '{'{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1'b1,
                        '{16'sd0, 16'sd0, 16'sd0, 1'b1}};
        dir_tab[6]  = '{'{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN}, 1'b1,
                        '{16'sd0, 16'sd0, 16'sd16384, 1'b0}};
        dir_tab[7]  = '{'{CMAX, CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN}, 1'b1,
                        '{16'sd16384, 16'sd0, 16'sd0, 1'b0}};
        dir_tab[8]  = '{'{5, 5, 5, 10, 10, 10, 20, 20, 20}, 1'b1,
                        '{16'sd0, 16'sd0, 16'sd0, 1'b1}};
        dir_tab[9]  = '{'{0, 0, 0, 1, 0, 0, 0, 1, 1}, 1'b0, none};
        dir_tab[10] = '{'{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX}, 1'b0, none};
        dir_tab[11] = '{'{CMAX, CMIN, 0, -1, CMAX, 1, CMIN, -1, CMAX}, 1'b0, none};

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        {i_p0_x, i_p0_y, i_p0_z, i_p1_x, i_p1_y, i_p1_z, i_p2_x, i_p2_y, i_p2_z} = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) send_tri(dir_tab[i].t, i, dir_tab[i].typed, dir_tab[i].e, 1'b0);
        for (int i = 0; i < N_RANDOM; i++) begin
            send_tri(random_tri(), i, 1'b0, none, i == 600);
        end
        i_valid <= 1'b0;
        while (normal_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
